>>> rtl/core/mlfq_pkg.sv
// mlfq_pkg: shared types, constants and command codes of the multilevel
// feedback scheduler; used by mlfq_ctrl, mlfq_dpath and the top level in rtl/core
`default_nettype none

package mlfq_pkg;

	localparam int LEVELS  = 4;
	localparam int THREADS = 64;
	localparam int ID_W    = 6;
	localparam int LV_W    = $clog2(LEVELS);
	localparam int SLOT_W  = $clog2(THREADS);
	localparam int FIFO_AW = LV_W + SLOT_W;
	localparam int CNT_W   = $clog2(THREADS + 1);
	localparam int RUNS_W  = 8;
	localparam int CFG_W   = 8;
	localparam int ROUND_W = 16;
	localparam int PER_W   = CNT_W + CFG_W;
	localparam int MSTEP_W = $clog2(ROUND_W);

	localparam logic [1:0] FUNC_CREATE = 2'd0;
	localparam logic [1:0] FUNC_TICK   = 2'd1;
	localparam logic [1:0] FUNC_YIELD  = 2'd2;
	localparam logic [1:0] FUNC_EXIT   = 2'd3;

	localparam logic CFG_BOOST_FACTOR    = 1'b0;
	localparam logic CFG_BOOST_THRESHOLD = 1'b1;

	localparam logic [4:0] OP_NONE   = 5'd0;
	localparam logic [4:0] OP_LOAD   = 5'd1;
	localparam logic [4:0] OP_CREATE = 5'd2;
	localparam logic [4:0] OP_RQ_RD  = 5'd3;
	localparam logic [4:0] OP_RQ_WR  = 5'd4;
	localparam logic [4:0] OP_ROUND  = 5'd5;
	localparam logic [4:0] OP_MOD    = 5'd6;
	localparam logic [4:0] OP_B_DQ   = 5'd7;
	localparam logic [4:0] OP_B_RD   = 5'd8;
	localparam logic [4:0] OP_B_WR   = 5'd9;
	localparam logic [4:0] OP_R_RD   = 5'd10;
	localparam logic [4:0] OP_R_LV   = 5'd11;
	localparam logic [4:0] OP_R_EN   = 5'd12;
	localparam logic [4:0] OP_D_DQ   = 5'd13;
	localparam logic [4:0] OP_D_RD   = 5'd14;
	localparam logic [4:0] OP_D_WR   = 5'd15;

	typedef struct packed {
		logic [1:0]      func;
		logic [ID_W-1:0] thread_id;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0]  run_thread;
		logic             run_valid;
		logic             full_error;
		logic [CNT_W-1:0] pending_count;
	} result_t;

	typedef struct packed {
		logic [4:0] op;
	} cmd_t;

	typedef struct packed {
		logic running_valid;
		logic pending_zero;
		logic mod_last;
		logic rem_zero;
		logic k_last;
	} status_t;

endpackage

`default_nettype wire

>>> rtl/core/mlfq_ram.sv
// mlfq_ram: generic one-write one-read memory with registered read data
// no dependencies
`default_nettype none

module mlfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/mlfq_ctrl.sv
// mlfq_ctrl: sequencer of the scheduler, issues at most one datapath command per cycle
// depends on mlfq_pkg
`default_nettype none

module mlfq_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [1:0]       func,
	input  wire mlfq_pkg::status_t status,
	output mlfq_pkg::cmd_t        cmd,
	output logic                  busy,
	output logic                  done
);

	import mlfq_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CREATE = 4'd1;
	localparam logic [3:0] ST_RQ_RD  = 4'd2;
	localparam logic [3:0] ST_RQ_WR  = 4'd3;
	localparam logic [3:0] ST_ROUND  = 4'd4;
	localparam logic [3:0] ST_MOD    = 4'd5;
	localparam logic [3:0] ST_CHK    = 4'd6;
	localparam logic [3:0] ST_B_DQ   = 4'd7;
	localparam logic [3:0] ST_B_RD   = 4'd8;
	localparam logic [3:0] ST_B_WR   = 4'd9;
	localparam logic [3:0] ST_R_RD   = 4'd10;
	localparam logic [3:0] ST_R_LV   = 4'd11;
	localparam logic [3:0] ST_R_EN   = 4'd12;
	localparam logic [3:0] ST_D_DQ   = 4'd13;
	localparam logic [3:0] ST_D_RD   = 4'd14;
	localparam logic [3:0] ST_D_WR   = 4'd15;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       done_q;
	logic       done_d;

	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		cmd.op  = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (start && !done_q) begin
					cmd.op = OP_LOAD;
					if (func == FUNC_CREATE) begin
						state_d = ST_CREATE;
					end else if (status.running_valid && func != FUNC_EXIT) begin
						state_d = ST_RQ_RD;
					end else begin
						state_d = ST_ROUND;
					end
				end
			end
			ST_CREATE: begin
				cmd.op  = OP_CREATE;
				state_d = ST_IDLE;
				done_d  = 1'b1;
			end
			ST_RQ_RD: begin
				cmd.op  = OP_RQ_RD;
				state_d = ST_RQ_WR;
			end
			ST_RQ_WR: begin
				cmd.op  = OP_RQ_WR;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.op = OP_ROUND;
				if (status.pending_zero) begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
				end else begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				cmd.op = OP_MOD;
				if (status.mod_last) begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				state_d = status.rem_zero ? ST_B_DQ : ST_D_DQ;
			end
			ST_B_DQ: begin
				cmd.op  = OP_B_DQ;
				state_d = ST_B_RD;
			end
			ST_B_RD: begin
				cmd.op  = OP_B_RD;
				state_d = ST_B_WR;
			end
			ST_B_WR: begin
				cmd.op  = OP_B_WR;
				state_d = status.k_last ? ST_R_RD : ST_B_DQ;
			end
			ST_R_RD: begin
				cmd.op  = OP_R_RD;
				state_d = ST_R_LV;
			end
			ST_R_LV: begin
				cmd.op  = OP_R_LV;
				state_d = ST_R_EN;
			end
			ST_R_EN: begin
				cmd.op  = OP_R_EN;
				state_d = status.k_last ? ST_D_DQ : ST_R_RD;
			end
			ST_D_DQ: begin
				cmd.op  = OP_D_DQ;
				state_d = ST_D_RD;
			end
			ST_D_RD: begin
				cmd.op  = OP_D_RD;
				state_d = ST_D_WR;
			end
			ST_D_WR: begin
				cmd.op  = OP_D_WR;
				state_d = ST_IDLE;
				done_d  = 1'b1;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != ST_IDLE) || done_q;
	assign done = done_q;

endmodule

`default_nettype wire

>>> rtl/core/mlfq_dpath.sv
// mlfq_dpath: queue pointers, thread tables, boost order buffer and
// period remainder unit; depends on mlfq_pkg and mlfq_ram
`default_nettype none

module mlfq_dpath (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire mlfq_pkg::cmd_t          cmd,
	input  wire mlfq_pkg::item_t         item,
	input  wire logic                    cfg_we,
	input  wire logic                    cfg_index,
	input  wire logic [mlfq_pkg::CFG_W-1:0] cfg_data,
	output mlfq_pkg::status_t            status,
	output mlfq_pkg::result_t            result
);

	import mlfq_pkg::*;

	logic [1:0]        func_q;
	logic [ID_W-1:0]   tid_q;
	logic [SLOT_W-1:0] head_q [LEVELS];
	logic [SLOT_W-1:0] tail_q [LEVELS];
	logic [CNT_W-1:0]  fill_q [LEVELS];
	logic [ID_W-1:0]   running_id_q;
	logic              running_valid_q;
	logic [ROUND_W-1:0] round_q;
	logic [CNT_W-1:0]  pending_q;
	logic [CFG_W-1:0]  factor_q;
	logic [CFG_W-1:0]  thresh_q;
	logic [PER_W-1:0]  period_q;
	logic [PER_W-1:0]  rem_q;
	logic [ROUND_W-1:0] quo_q;
	logic [MSTEP_W-1:0] mcnt_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  k_q;
	logic [ID_W-1:0]   id_q;
	logic              full_q;

	logic [LV_W-1:0]   best_lv;
	logic              enq_en;
	logic [LV_W-1:0]   enq_lv;
	logic [ID_W-1:0]   enq_id;
	logic              deq_en;
	logic              room_full;
	logic [ROUND_W-1:0] round_inc;
	logic [PER_W:0]    mod_r;
	logic [LV_W-1:0]   rq_lv;

	logic              fifo_we;
	logic [FIFO_AW-1:0] fifo_raddr;
	logic [ID_W-1:0]   fifo_rdata;
	logic              lvl_we;
	logic [SLOT_W-1:0] lvl_waddr;
	logic [LV_W-1:0]   lvl_wdata;
	logic [SLOT_W-1:0] lvl_raddr;
	logic [LV_W-1:0]   lvl_rdata;
	logic              runs_we;
	logic [SLOT_W-1:0] runs_waddr;
	logic [RUNS_W-1:0] runs_wdata;
	logic [SLOT_W-1:0] runs_raddr;
	logic [RUNS_W-1:0] runs_rdata;
	logic              ord_we;
	logic [ID_W-1:0]   ord_rdata;

	always_comb begin
		best_lv = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (fill_q[i] != '0) begin
				best_lv = LV_W'(i);
			end
		end
	end

	assign room_full = (pending_q + CNT_W'(running_valid_q)) >= CNT_W'(THREADS);
	assign round_inc = round_q + ROUND_W'(1);
	assign mod_r     = {rem_q, quo_q[ROUND_W-1]};
	assign rq_lv     = (func_q == FUNC_TICK && lvl_rdata != '0) ? lvl_rdata - LV_W'(1)
		: lvl_rdata;

	always_comb begin
		enq_en = 1'b0;
		enq_lv = '0;
		enq_id = '0;
		case (cmd.op)
			OP_CREATE: begin
				enq_en = !room_full;
				enq_lv = LV_W'(LEVELS - 1);
				enq_id = tid_q;
			end
			OP_RQ_WR: begin
				enq_en = 1'b1;
				enq_lv = rq_lv;
				enq_id = running_id_q;
			end
			OP_R_EN: begin
				enq_en = 1'b1;
				enq_lv = lvl_rdata;
				enq_id = id_q;
			end
			default: begin
				enq_en = 1'b0;
			end
		endcase
	end

	assign deq_en  = (cmd.op == OP_B_DQ) || (cmd.op == OP_D_DQ);
	assign fifo_we = enq_en;
	assign fifo_raddr = {best_lv, head_q[best_lv]};

	always_comb begin
		lvl_we     = 1'b0;
		lvl_waddr  = tid_q;
		lvl_wdata  = LV_W'(LEVELS - 1);
		lvl_raddr  = running_id_q;
		runs_we    = 1'b0;
		runs_waddr = tid_q;
		runs_wdata = '0;
		runs_raddr = fifo_rdata;
		case (cmd.op)
			OP_CREATE: begin
				lvl_we  = !room_full;
				runs_we = !room_full;
			end
			OP_RQ_WR: begin
				lvl_we    = 1'b1;
				lvl_waddr = running_id_q;
				lvl_wdata = rq_lv;
			end
			OP_B_RD: begin
				lvl_raddr = fifo_rdata;
			end
			OP_B_WR: begin
				lvl_we     = 1'b1;
				lvl_waddr  = id_q;
				lvl_wdata  = (runs_rdata < thresh_q && lvl_rdata != LV_W'(LEVELS - 1))
					? lvl_rdata + LV_W'(1) : lvl_rdata;
				runs_we    = 1'b1;
				runs_waddr = id_q;
			end
			OP_R_LV: begin
				lvl_raddr = ord_rdata;
			end
			OP_D_WR: begin
				runs_we    = 1'b1;
				runs_waddr = id_q;
				runs_wdata = (runs_rdata == '1) ? runs_rdata : runs_rdata + RUNS_W'(1);
			end
			default: begin
				lvl_we = 1'b0;
			end
		endcase
	end

	assign ord_we = (cmd.op == OP_B_WR);

	mlfq_ram #(.WIDTH(ID_W), .DEPTH(LEVELS * THREADS)) u_fifo_ram (
		.clk   (clk),
		.we    (fifo_we),
		.waddr ({enq_lv, tail_q[enq_lv]}),
		.wdata (enq_id),
		.raddr (fifo_raddr),
		.rdata (fifo_rdata)
	);

	mlfq_ram #(.WIDTH(LV_W), .DEPTH(THREADS)) u_level_ram (
		.clk   (clk),
		.we    (lvl_we),
		.waddr (lvl_waddr),
		.wdata (lvl_wdata),
		.raddr (lvl_raddr),
		.rdata (lvl_rdata)
	);

	mlfq_ram #(.WIDTH(RUNS_W), .DEPTH(THREADS)) u_runs_ram (
		.clk   (clk),
		.we    (runs_we),
		.waddr (runs_waddr),
		.wdata (runs_wdata),
		.raddr (runs_raddr),
		.rdata (runs_rdata)
	);

	mlfq_ram #(.WIDTH(ID_W), .DEPTH(THREADS)) u_order_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (k_q[SLOT_W-1:0]),
		.wdata (id_q),
		.raddr (k_q[SLOT_W-1:0]),
		.rdata (ord_rdata)
	);

	// queue pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
			pending_q <= '0;
		end else if (enq_en) begin
			tail_q[enq_lv] <= (tail_q[enq_lv] == SLOT_W'(THREADS - 1)) ? '0
				: tail_q[enq_lv] + SLOT_W'(1);
			fill_q[enq_lv] <= fill_q[enq_lv] + CNT_W'(1);
			pending_q      <= pending_q + CNT_W'(1);
		end else if (deq_en) begin
			head_q[best_lv] <= (head_q[best_lv] == SLOT_W'(THREADS - 1)) ? '0
				: head_q[best_lv] + SLOT_W'(1);
			fill_q[best_lv] <= fill_q[best_lv] - CNT_W'(1);
			pending_q       <= pending_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_id_q    <= '0;
			running_valid_q <= 1'b0;
			round_q         <= ROUND_W'(1);
			factor_q        <= CFG_W'(2);
			thresh_q        <= CFG_W'(1);
			full_q          <= 1'b0;
			func_q          <= FUNC_CREATE;
			k_q             <= '0;
			mcnt_q          <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BOOST_FACTOR:    factor_q <= cfg_data;
					CFG_BOOST_THRESHOLD: thresh_q <= cfg_data;
					default:             factor_q <= factor_q;
				endcase
			end
			case (cmd.op)
				OP_LOAD: begin
					func_q <= item.func;
					full_q <= 1'b0;
				end
				OP_CREATE: begin
					full_q <= room_full;
				end
				OP_ROUND: begin
					round_q         <= round_inc;
					running_valid_q <= 1'b0;
					mcnt_q          <= '0;
					k_q             <= '0;
					if (pending_q == '0) begin
						running_id_q <= '0;
					end
				end
				OP_MOD: begin
					mcnt_q <= mcnt_q + MSTEP_W'(1);
				end
				OP_B_WR: begin
					k_q <= status.k_last ? '0 : k_q + CNT_W'(1);
				end
				OP_R_EN: begin
					k_q <= k_q + CNT_W'(1);
				end
				OP_D_RD: begin
					running_id_q    <= fifo_rdata;
					running_valid_q <= 1'b1;
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				tid_q <= item.thread_id;
			end
			OP_ROUND: begin
				period_q <= PER_W'(pending_q) * PER_W'(factor_q) + PER_W'(1);
				n_q      <= pending_q;
				rem_q    <= '0;
				quo_q    <= round_inc;
			end
			OP_MOD: begin
				rem_q <= (mod_r >= {1'b0, period_q}) ? PER_W'(mod_r - {1'b0, period_q})
					: PER_W'(mod_r);
				quo_q <= {quo_q[ROUND_W-2:0], 1'b0};
			end
			OP_B_RD, OP_D_RD: begin
				id_q <= fifo_rdata;
			end
			OP_R_LV: begin
				id_q <= ord_rdata;
			end
			default: begin
				id_q <= id_q;
			end
		endcase
	end

	assign status.running_valid = running_valid_q;
	assign status.pending_zero  = (pending_q == '0);
	assign status.mod_last      = (mcnt_q == MSTEP_W'(ROUND_W - 1));
	assign status.rem_zero      = (rem_q == '0);
	assign status.k_last        = (k_q == n_q - CNT_W'(1));

	assign result.run_thread    = (func_q != FUNC_CREATE && running_valid_q) ? running_id_q
		: '0;
	assign result.run_valid     = (func_q != FUNC_CREATE) && running_valid_q;
	assign result.full_error    = full_q;
	assign result.pending_count = pending_q;

endmodule

`default_nettype wire

>>> rtl/core/multilevel_feedback_scheduler.sv
// multilevel_feedback_scheduler: top level, joins sequencer and datapath
// depends on mlfq_pkg, mlfq_ctrl, mlfq_dpath, mlfq_ram
// tick, yield or exit run the 16-step remainder unit for the boost period
// when threads are pending; a boost makes two passes over the queued
// threads through the one-write one-read tables
// one item at a time: busy is high through the done cycle; results cannot stall
// async reset clears queues, counters and control registers; tables need none
`default_nettype none

module multilevel_feedback_scheduler (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire mlfq_pkg::item_t             item,
	output logic                             done,
	output mlfq_pkg::result_t                result,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [mlfq_pkg::CFG_W-1:0]  cfg_data
);

	import mlfq_pkg::*;

	cmd_t    cmd;
	status_t status;

	mlfq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (item.func),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mlfq_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.result    (result)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("transfer did not raise busy");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result while idle");
	a_full_norun: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.full_error |-> !result.run_valid) else $error("full with dispatch");
	a_pending_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.pending_count <= CNT_W'(THREADS)) else $error("pending overflow");
`endif

endmodule

`default_nettype wire

>>> dv/multilevel_feedback_scheduler_tb.sv
// testbench for multilevel_feedback_scheduler: drives create/tick/yield/exit
// commands and register writes, checks every result against a behavioral scheduler
// depends on mlfq_pkg and the scheduler rtl
`default_nettype none

module multilevel_feedback_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mlfq_pkg::*;

	class sched_scoreboard;
		logic [ID_W-1:0] lvq [LEVELS][$];
		logic [1:0] thr_level [THREADS];
		logic [7:0] thr_runs [THREADS];
		logic [ID_W-1:0] cur_id;
		bit cur_valid;
		logic [15:0] round_no;
		logic [7:0] boost_factor;
		logic [7:0] boost_threshold;
		result_t due_q [$];
		int errors;
		int boosts;
		int fulls;

		function new();
			for (int i = 0; i < THREADS; i++) begin
				thr_level[i] = '0;
				thr_runs[i] = '0;
			end
			cur_id = '0;
			cur_valid = 0;
			round_no = 16'd1;
			boost_factor = 8'd2;
			boost_threshold = 8'd1;
			errors = 0;
			boosts = 0;
			fulls = 0;
		endfunction

		function int waiting();
			int n;
			n = 0;
			for (int l = 0; l < LEVELS; l++)
				n += lvq[l].size();
			return n;
		endfunction

		function logic [ID_W-1:0] take_best();
			for (int l = LEVELS - 1; l >= 0; l--)
				if (lvq[l].size() > 0)
					return lvq[l].pop_front();
			return '0;
		endfunction

		function void set_reg(logic idx, logic [7:0] val);
			if (idx == CFG_BOOST_FACTOR)
				boost_factor = val;
			else
				boost_threshold = val;
		endfunction

		function void note_item(item_t it);
			result_t r;
			int pend;
			int period;
			logic [ID_W-1:0] order [$];
			logic [ID_W-1:0] id;
			r = '0;
			if (it.func == FUNC_CREATE) begin
				if (waiting() + (cur_valid ? 1 : 0) >= THREADS) begin
					r.full_error = 1'b1;
					fulls++;
				end else begin
					thr_level[it.thread_id] = 2'(LEVELS - 1);
					thr_runs[it.thread_id] = '0;
					lvq[LEVELS - 1].push_back(it.thread_id);
				end
			end else begin
				if (cur_valid) begin
					if (it.func == FUNC_TICK) begin
						if (thr_level[cur_id] > 0)
							thr_level[cur_id]--;
						lvq[thr_level[cur_id]].push_back(cur_id);
					end else if (it.func == FUNC_YIELD) begin
						lvq[thr_level[cur_id]].push_back(cur_id);
					end
					cur_valid = 0;
				end
				round_no = round_no + 16'd1;
				pend = waiting();
				if (pend > 0) begin
					period = pend * boost_factor + 1;
					if (int'(round_no) % period == 0) begin
						boosts++;
						for (int k = 0; k < pend; k++) begin
							id = take_best();
							if (thr_runs[id] < boost_threshold && thr_level[id] < LEVELS - 1)
								thr_level[id]++;
							thr_runs[id] = '0;
							order.push_back(id);
						end
						foreach (order[k])
							lvq[thr_level[order[k]]].push_back(order[k]);
					end
					id = take_best();
					cur_id = id;
					cur_valid = 1;
					if (thr_runs[id] < 255)
						thr_runs[id]++;
				end else begin
					cur_id = '0;
				end
				r.run_thread = cur_valid ? cur_id : '0;
				r.run_valid = cur_valid;
			end
			r.pending_count = CNT_W'(waiting());
			due_q.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(result_t got);
			result_t exp;
			if (due_q.size() == 0) begin
				report($sformatf("unexpected result %p", got));
				return;
			end
			exp = due_q.pop_front();
			if (got.run_thread !== exp.run_thread)
				report($sformatf("run_thread %0d exp %0d", got.run_thread, exp.run_thread));
			if (got.run_valid !== exp.run_valid)
				report($sformatf("run_valid %0d exp %0d", got.run_valid, exp.run_valid));
			if (got.full_error !== exp.full_error)
				report($sformatf("full_error %0d exp %0d", got.full_error, exp.full_error));
			if (got.pending_count !== exp.pending_count)
				report($sformatf("pending_count %0d exp %0d", got.pending_count,
					exp.pending_count));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	item_t item;
	logic done;
	result_t result;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_data;

	sched_scoreboard sb;
	int idle_cycles;
	int sent;
	bit no_gaps;

	multilevel_feedback_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
		if ((start && !busy) || done)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles > 20000) begin
			$display("timeout, no transfer for %0d cycles", idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// start stays high between back-to-back items; it drops only for gaps and drains
	task automatic send(logic [1:0] f, logic [ID_W-1:0] tid);
		item_t it;
		it.func = f;
		it.thread_id = tid;
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			start <= 0;
			item <= {2'($urandom_range(0, 3)), 6'($urandom)};
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		start <= 1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_item(it);
		sent++;
	endtask

	task automatic drain();
		start <= 0;
		while (sb.due_q.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// picks creates with the given percentage, otherwise ticks, yields and exits
	task automatic random_items(int n, int create_pct);
		int p;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 99);
			if (p < create_pct)
				send(FUNC_CREATE, 6'($urandom));
			else if (p < create_pct + 40)
				send(FUNC_TICK, 6'($urandom));
			else if (p < create_pct + 75)
				send(FUNC_YIELD, 6'($urandom));
			else
				send(FUNC_EXIT, 6'($urandom));
		end
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		start = 0;
		item = '0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		idle_cycles = 0;
		sent = 0;
		no_gaps = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: idle rounds, extreme ids, every command, duplicate create
		send(FUNC_TICK, 6'd0);
		send(FUNC_YIELD, 6'd63);
		send(FUNC_EXIT, 6'd0);
		send(FUNC_CREATE, 6'd0);
		send(FUNC_CREATE, 6'd63);
		send(FUNC_CREATE, 6'd63);
		send(FUNC_CREATE, 6'd42);
		send(FUNC_CREATE, 6'd21);
		send(FUNC_TICK, 6'd63);
		send(FUNC_TICK, 6'd0);
		send(FUNC_YIELD, 6'd0);
		send(FUNC_TICK, 6'd0);
		send(FUNC_TICK, 6'd0);
		send(FUNC_TICK, 6'd0);
		send(FUNC_TICK, 6'd0);
		send(FUNC_EXIT, 6'd0);
		send(FUNC_YIELD, 6'd0);
		send(FUNC_EXIT, 6'd0);
		send(FUNC_EXIT, 6'd0);
		send(FUNC_EXIT, 6'd0);
		send(FUNC_EXIT, 6'd0);
		send(FUNC_EXIT, 6'd0);
		drain();

		// boost every round, high threshold
		write_reg(CFG_BOOST_FACTOR, 8'd0);
		write_reg(CFG_BOOST_THRESHOLD, 8'd255);
		random_items(150, 40);
		drain();

		// fill to capacity to hit the full error
		write_reg(CFG_BOOST_FACTOR, 8'd255);
		write_reg(CFG_BOOST_THRESHOLD, 8'd0);
		for (int i = 0; i < 70; i++)
			send(FUNC_CREATE, 6'($urandom));
		random_items(150, 20);
		drain();

		write_reg(CFG_BOOST_FACTOR, 8'd1);
		write_reg(CFG_BOOST_THRESHOLD, 8'd3);
		random_items(300, 30);
		drain();

		write_reg(CFG_BOOST_FACTOR, 8'($urandom_range(0, 4)));
		write_reg(CFG_BOOST_THRESHOLD, 8'($urandom));
		random_items(300, 35);
		drain();

		// closing stretch with no gaps
		no_gaps = 1;
		write_reg(CFG_BOOST_FACTOR, 8'd2);
		write_reg(CFG_BOOST_THRESHOLD, 8'd1);
		random_items(230, 30);
		drain();

		$display("%0d commands sent, %0d boosts and %0d full creates predicted",
			sent, sb.boosts, sb.fulls);
		if (sb.errors == 0 && sb.due_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

`default_nettype wire
